### rtl/base64_decoder_defines.svh
// Assertion macros shared by the base64 decoder RTL.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef BASE64_DECODER_DEFINES_SVH
`define BASE64_DECODER_DEFINES_SVH

// condition holds at every edge out of reset
`define B64D_ASSERT_NOW(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// same-cycle implication
`define B64D_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define B64D_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/b64d_pkg.sv
// Package for the base64 decoder: character classes, queue command type,
// character decode function. No dependencies.
package b64d_pkg;

    localparam logic [7:0] CHAR_PAD   = 8'h3D;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_SLASH = 8'h2F;
    localparam logic [5:0] SEXTET_PLUS  = 6'd62;
    localparam logic [5:0] SEXTET_SLASH = 6'd63;

    typedef enum logic [1:0] {
        CLS_DATA,
        CLS_PAD,
        CLS_SPACE,
        CLS_BAD
    } char_class_t;

    typedef struct packed {
        char_class_t cls;
        logic [5:0]  value;
    } sextet_t;

    // one queued request: up to three bytes, plus end-of-message marking
    typedef struct packed {
        logic [23:0] bits;
        logic [1:0]  nbytes;
        logic        eom;
        logic        err;
    } cmd_t;

    typedef struct packed {
        logic [7:0] byte_out;
        logic       byte_valid;
        logic       error_flag;
        logic       end_of_message;
    } result_t;

    function automatic sextet_t decode_char(input logic [7:0] c);
        sextet_t r;
        r.cls   = CLS_BAD;
        r.value = '0;
        if (c >= 8'h41 && c <= 8'h5A)
        begin
            r.cls   = CLS_DATA;
            r.value = 6'(c - 8'h41);
        end
        else if (c >= 8'h61 && c <= 8'h7A)
        begin
            r.cls   = CLS_DATA;
            r.value = 6'(c - 8'h61 + 8'd26);
        end
        else if (c >= 8'h30 && c <= 8'h39)
        begin
            r.cls   = CLS_DATA;
            r.value = 6'(c - 8'h30 + 8'd52);
        end
        else if (c == CHAR_PLUS)
        begin
            r.cls   = CLS_DATA;
            r.value = SEXTET_PLUS;
        end
        else if (c == CHAR_SLASH)
        begin
            r.cls   = CLS_DATA;
            r.value = SEXTET_SLASH;
        end
        else if (c == CHAR_PAD)
        begin
            r.cls = CLS_PAD;
        end
        else if (c == CHAR_SPACE || c == CHAR_TAB || c == CHAR_LF || c == CHAR_CR)
        begin
            r.cls = CLS_SPACE;
        end
        return r;
    endfunction

endpackage

### rtl/b64d_char_if.sv
// Character channel of the base64 decoder: valid/ready plus one character.
// No dependencies.
interface b64d_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_in;
    logic       last_in;

    modport source (output valid, output char_in, output last_in, input ready);
    modport sink   (input valid, input char_in, input last_in, output ready);
endinterface

### rtl/b64d_byte_if.sv
// Byte channel of the base64 decoder: valid/ready plus one decoded result.
// No dependencies.
interface b64d_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_out;
    logic       byte_valid;
    logic       error_flag;
    logic       end_of_message;

    modport source (output valid, output byte_out, output byte_valid,
                    output error_flag, output end_of_message, input ready);
    modport sink   (input valid, input byte_out, input byte_valid,
                    input error_flag, input end_of_message, output ready);
endinterface

### rtl/base64_decoder.sv
// Streaming base64 text decoder, top level.
// Characters enter on char_stream (char_in, last_in) with a valid/ready
// handshake; one character is taken per cycle while the request queue has room.
// Space, tab, CR and LF are skipped; other characters that are not base64
// letters or '=' mark the message as bad. Four significant characters form a
// group that is held until the next significant character (three bytes out)
// or the end of the message (three bytes less one per trailing '=').
// Results leave on byte_stream, one per cycle, through an output register.
// The final result of a message has end_of_message set and carries
// error_flag; if nothing else is due it is a lone result with byte_valid 0.
// Each request is stored in the queue; its results leave through the output register.
// Throughput: one character per cycle while the queue has room, one result per
// cycle while byte_stream.ready is high; a group of four characters gives at most
// three results, so at the default QUEUE_DEPTH the queue never fills while ready is high.
// When the receiver stalls the output register holds and the queue fills,
// after which char_stream.ready drops. Reset clears all group state and
// empties the queue; there is no clearing pass.
// Depends on b64d_pkg, b64d_char_if, b64d_byte_if and the submodules.
module base64_decoder #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    b64d_char_if.sink   char_stream,
    b64d_byte_if.source byte_stream
);
    import b64d_pkg::*;

    logic push;
    logic pop;
    logic full;
    logic empty;
    cmd_t push_cmd;
    cmd_t head;

    b64d_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .char_stream (char_stream),
        .queue_full  (full),
        .push        (push),
        .push_cmd    (push_cmd)
    );

    b64d_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .full     (full),
        .empty    (empty)
    );

    b64d_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .empty       (empty),
        .pop         (pop),
        .byte_stream (byte_stream)
    );

endmodule

### rtl/b64d_front.sv
// Front end: accepts characters, gathers groups, pushes release and end-of-message requests.
// Depends on b64d_pkg, b64d_char_if, base64_decoder_defines.svh.
`include "base64_decoder_defines.svh"

module b64d_front (
    input  logic            clk,
    input  logic            rst_n,
    b64d_char_if.sink       char_stream,
    input  logic            queue_full,
    output logic            push,
    output b64d_pkg::cmd_t  push_cmd
);
    import b64d_pkg::*;

    logic [23:0] group_bits_reg,  group_bits_next;
    logic [1:0]  group_count_reg, group_count_next;
    logic [1:0]  group_pads_reg,  group_pads_next;
    logic [23:0] held_bits_reg,   held_bits_next;
    logic [1:0]  held_pads_reg,   held_pads_next;
    logic        held_valid_reg,  held_valid_next;
    logic        failed_reg,      failed_next;

    sextet_t     sx;
    logic        accept;
    logic        signif;
    logic        release_held;
    logic [23:0] shifted;

    assign char_stream.ready = !queue_full;
    assign accept = char_stream.valid && !queue_full;
    assign sx     = decode_char(char_stream.char_in);
    assign signif = (sx.cls != CLS_SPACE) && !failed_reg;

    always_comb
    begin
        group_bits_next  = group_bits_reg;
        group_count_next = group_count_reg;
        group_pads_next  = group_pads_reg;
        held_bits_next   = held_bits_reg;
        held_pads_next   = held_pads_reg;
        held_valid_next  = held_valid_reg;
        failed_next      = failed_reg;
        release_held     = 1'b0;
        shifted          = {group_bits_reg[17:0], sx.value};
        push             = 1'b0;
        push_cmd         = '0;

        if (accept)
        begin
            if (signif && sx.cls == CLS_BAD)
            begin
                failed_next = 1'b1;
            end
            else if (signif)
            begin
                release_held    = held_valid_reg;
                held_valid_next = 1'b0;
                if (sx.cls == CLS_PAD)
                begin
                    if (group_pads_reg < 2'd2)
                        group_pads_next = group_pads_reg + 2'd1;
                end
                else
                begin
                    group_pads_next = '0;
                end
                group_bits_next  = shifted;
                group_count_next = group_count_reg + 2'd1;
                if (group_count_reg == 2'd3)
                begin
                    held_bits_next   = shifted;
                    held_pads_next   = group_pads_next;
                    held_valid_next  = 1'b1;
                    group_bits_next  = '0;
                    group_count_next = '0;
                    group_pads_next  = '0;
                end
            end

            push_cmd.eom = char_stream.last_in;
            push_cmd.err = failed_next;
            if (release_held)
            begin
                push_cmd.bits   = held_bits_reg;
                push_cmd.nbytes = 2'd3;
            end
            else if (char_stream.last_in && held_valid_next && !failed_next)
            begin
                push_cmd.bits   = held_bits_next;
                push_cmd.nbytes = 2'd3 - held_pads_next;
            end
            push = release_held || char_stream.last_in;

            if (char_stream.last_in)
            begin
                group_bits_next  = '0;
                group_count_next = '0;
                group_pads_next  = '0;
                held_bits_next   = '0;
                held_pads_next   = '0;
                held_valid_next  = 1'b0;
                failed_next      = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            group_bits_reg  <= '0;
            group_count_reg <= '0;
            group_pads_reg  <= '0;
            held_bits_reg   <= '0;
            held_pads_reg   <= '0;
            held_valid_reg  <= 1'b0;
            failed_reg      <= 1'b0;
        end
        else
        begin
            group_bits_reg  <= group_bits_next;
            group_count_reg <= group_count_next;
            group_pads_reg  <= group_pads_next;
            held_bits_reg   <= held_bits_next;
            held_pads_reg   <= held_pads_next;
            held_valid_reg  <= held_valid_next;
            failed_reg      <= failed_next;
        end
    end

    // a held group is always followed by an empty gathering group
    `B64D_ASSERT_IMPLY(a_held_group_empty, held_valid_reg, group_count_reg == 2'd0,
        "held group with partial group behind it")
    `B64D_ASSERT_IMPLY(a_pads_need_chars, group_pads_reg != 2'd0, group_count_reg != 2'd0,
        "pad count without characters")

endmodule

### rtl/b64d_queue.sv
// Short request queue between front and back end of the base64 decoder.
// Depends on b64d_pkg, base64_decoder_defines.svh.
`include "base64_decoder_defines.svh"

module b64d_queue #(
    parameter int DEPTH = 4
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  b64d_pkg::cmd_t  push_cmd,
    input  logic            pop,
    output b64d_pkg::cmd_t  head,
    output logic            full,
    output logic            empty
);
    import b64d_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    cmd_t          entries_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg,  count_next;

    assign full  = (count_reg == CW'(DEPTH));
    assign empty = (count_reg == '0);
    assign head  = entries_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        case ({push, pop})
            2'b10:   count_next = count_reg + CW'(1);
            2'b01:   count_next = count_reg - CW'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entries_reg[wr_ptr_reg] <= push_cmd;
    end

    `B64D_ASSERT_NOW(a_count_bound, count_reg <= CW'(DEPTH), "queue count past depth")
    `B64D_ASSERT_NEXT(a_count_step, push && !pop, count_reg == $past(count_reg) + CW'(1),
        "queue count missed a push")

endmodule

### rtl/b64d_back.sv
// Back end: splits queued requests into bytes behind an output register.
// Depends on b64d_pkg, b64d_byte_if, base64_decoder_defines.svh.
`include "base64_decoder_defines.svh"

module b64d_back (
    input  logic            clk,
    input  logic            rst_n,
    input  b64d_pkg::cmd_t  head,
    input  logic            empty,
    output logic            pop,
    b64d_byte_if.source     byte_stream
);
    import b64d_pkg::*;

    logic [1:0] idx_reg,       idx_next;
    logic       out_valid_reg, out_valid_next;
    result_t    out_reg,       out_next;
    logic       load;
    logic       final_piece;
    logic [7:0] sel_byte;

    assign load        = !out_valid_reg || byte_stream.ready;
    assign final_piece = (head.nbytes == 2'd0) || (idx_reg == head.nbytes - 2'd1);

    always_comb
    begin
        case (idx_reg)
            2'd0:    sel_byte = head.bits[23:16];
            2'd1:    sel_byte = head.bits[15:8];
            default: sel_byte = head.bits[7:0];
        endcase
    end

    always_comb
    begin
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        pop            = 1'b0;
        if (load)
        begin
            out_valid_next = !empty;
            if (!empty)
            begin
                out_next.byte_valid     = (head.nbytes != 2'd0);
                out_next.byte_out       = (head.nbytes != 2'd0) ? sel_byte : 8'h00;
                out_next.end_of_message = head.eom && final_piece;
                out_next.error_flag     = head.eom && final_piece && head.err;
                if (final_piece)
                begin
                    pop      = 1'b1;
                    idx_next = '0;
                end
                else
                begin
                    idx_next = idx_reg + 2'd1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign byte_stream.valid          = out_valid_reg;
    assign byte_stream.byte_out       = out_reg.byte_out;
    assign byte_stream.byte_valid     = out_reg.byte_valid;
    assign byte_stream.error_flag     = out_reg.error_flag;
    assign byte_stream.end_of_message = out_reg.end_of_message;

    // a part-sent request stays at the head of the queue
    `B64D_ASSERT_IMPLY(a_idx_in_request, idx_reg != 2'd0,
        !empty && idx_reg < head.nbytes, "byte index outside queued request")

endmodule
